// ===== design/rtd_pkg.sv =====
package rtd_pkg;

	// Default width of the converted value.
	localparam int VALUE_BITS_DEF = 32;

	// Widths of the fixed fields.
	localparam int IN_W    = 32;
	localparam int DIGIT_W = 4;
	localparam int BASE_W  = 5;

	// Radix register reset value and its usable range.
	localparam logic [BASE_W-1:0] BASE_RESET = BASE_W'(10);
	localparam logic [BASE_W-1:0] BASE_MIN   = BASE_W'(2);
	localparam logic [BASE_W-1:0] BASE_MAX   = BASE_W'(16);

	// Clamp the register contents into the supported radix range.
	function automatic logic [BASE_W-1:0] sat_base(input logic [BASE_W-1:0] raw);
		logic [BASE_W-1:0] b;
		b = raw;
		if (raw < BASE_MIN) begin
			b = BASE_MIN;
		end else if (raw > BASE_MAX) begin
			b = BASE_MAX;
		end
		return b;
	endfunction

	// Index of the highest digit bit that a digit below the radix can have.
	function automatic logic [1:0] top_bit(input logic [BASE_W-1:0] base);
		logic [1:0] t;
		t = 2'd0;
		if (base > BASE_W'(8)) begin
			t = 2'd3;
		end else if (base > BASE_W'(4)) begin
			t = 2'd2;
		end else if (base > BASE_W'(2)) begin
			t = 2'd1;
		end
		return t;
	endfunction

endpackage

// ===== design/integer_to_radix_digits_unit.sv =====
// Steps: a value is taken in idle, the place powers of the radix are built and pushed onto the
// stack, and then each digit, highest place first, is loaded from the stack, found by k restoring
// subtract steps and offered, where k is 1 for radix 2, 2 up to 4, 3 up to 8 and 4 up to 16.
// The input is ready again only once the last digit word is taken; no new value is taken before
// then. The power search runs on the single multiply-compare unit, one place power per cycle.
// Reset (arst_n, asynchronous, active low) idles the block and sets the radix to ten.
module integer_to_radix_digits_unit
	import rtd_pkg::*;
#(
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [BASE_W-1:0]  cfg_wdata,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [IN_W-1:0]    value,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [DIGIT_W-1:0] digit,
	output logic               last_digit
);

	// Only the low VALUE_BITS bits of the input word take part, and the input word is IN_W wide.
	localparam int VW = (VALUE_BITS < IN_W) ? VALUE_BITS : IN_W;
	// A power of the radix never exceeds the value; its product with the radix needs BASE_W more bits.
	localparam int PW = VW + BASE_W;
	// A place power shifted by up to three digit bits.
	localparam int TW = VW + 3;
	// One stack entry per possible digit; radix two gives the most digits.
	localparam int AW = $clog2(VW);

	typedef enum logic [2:0] {
		S_IDLE,
		S_GROW,
		S_LOAD,
		S_DIV,
		S_OUT
	} state_t;

	state_t             state_q;
	logic [BASE_W-1:0]  target_base_q;
	logic [BASE_W-1:0]  base_q;
	logic [VW-1:0]      val_q;
	logic [VW-1:0]      power_q;
	logic [VW-1:0]      rem_q;
	logic [AW-1:0]      idx_q;
	logic [1:0]         bit_q;
	logic [DIGIT_W-1:0] digit_q;

	logic [PW-1:0] next_power;
	logic          power_fits;
	logic [TW-1:0] trial;
	logic          trial_fits;
	logic [VW-1:0] stack_rd_data;

	// The radix register is written whenever enabled; the user must change it only while the block idles (not enforced).
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_base_q <= BASE_RESET;
		end else if (cfg_we) begin
			target_base_q <= cfg_wdata;
		end
	end

	// The single multiplier: the next power of the radix, tested against the value.
	assign next_power = PW'(power_q) * PW'(base_q);
	assign power_fits = next_power <= PW'(val_q);

	// One restoring step of the digit division: the place power scaled by the current digit bit.
	assign trial      = TW'(stack_rd_data) << bit_q;
	assign trial_fits = TW'(rem_q) >= trial;

	// The place powers are pushed onto a stack while growing and popped, highest first, per digit.
	rtd_ram #(
		.WIDTH(VW),
		.DEPTH(VW)
	) u_power_stack (
		.clk    (clk),
		.wr_en  (state_q == S_GROW),
		.wr_addr(idx_q),
		.wr_data(power_q),
		.rd_addr(idx_q),
		.rd_data(stack_rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			base_q  <= BASE_RESET;
			val_q   <= '0;
			power_q <= '0;
			rem_q   <= '0;
			idx_q   <= '0;
			bit_q   <= '0;
			digit_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						// Start from the units place; a zero value ends up as one digit zero.
						base_q  <= sat_base(target_base_q);
						val_q   <= value[VW-1:0];
						rem_q   <= value[VW-1:0];
						power_q <= VW'(1);
						idx_q   <= '0;
						state_q <= S_GROW;
					end
				end
				S_GROW: begin
					// The current power has just been pushed; climb while the next one still fits.
					if (power_fits) begin
						power_q <= next_power[VW-1:0];
						idx_q   <= idx_q + AW'(1);
					end else begin
						state_q <= S_LOAD;
					end
				end
				S_LOAD: begin
					// The stack read of this place's power is registered here, for use in S_DIV.
					digit_q <= '0;
					bit_q   <= top_bit(base_q);
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (trial_fits) begin
						rem_q          <= rem_q - trial[VW-1:0];
						digit_q[bit_q] <= 1'b1;
					end
					if (bit_q == 2'd0) begin
						state_q <= S_OUT;
					end else begin
						bit_q <= bit_q - 2'd1;
					end
				end
				S_OUT: begin
					if (out_ready) begin
						if (idx_q == '0) begin
							state_q <= S_IDLE;
						end else begin
							idx_q   <= idx_q - AW'(1);
							state_q <= S_LOAD;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_ready   = (state_q == S_IDLE);
	assign out_valid  = (state_q == S_OUT);
	assign digit      = digit_q;
	// The units place sits at the bottom of the stack, so it is the final digit.
	assign last_digit = (idx_q == '0);

	// A value is never taken while a digit word is on offer.
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input ready while a digit word is offered");

	// Every digit word lies below the radix used for its value.
	a_digit_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (BASE_W'(digit) < base_q))
		else $error("digit not below the radix");

	// Taking the final digit word returns the block to idle.
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && last_digit) |=> in_ready)
		else $error("block not idle after the final digit");

	// While climbing, the place power never exceeds the value.
	a_power_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_GROW && val_q != '0) |-> (power_q <= val_q))
		else $error("place power above the value");

	// An accepted value is never answered without first building its place powers.
	a_accept_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == S_GROW))
		else $error("accepted value did not start the power search");

endmodule

// ===== design/rtd_ram.sv =====
module rtd_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

// ===== sim/radix_digit_checker.sv =====
module radix_digit_checker
	import rtd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [BASE_W-1:0]  cfg_wdata,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic [IN_W-1:0]    value,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic [DIGIT_W-1:0] digit,
	input  logic               last_digit,
	output int                 mismatches,
	output int                 digits_outstanding
);

	typedef struct packed {
		logic [DIGIT_W-1:0] digit;
		logic               is_last;
	} digit_word_t;

	digit_word_t       digits_due[$];
	digit_word_t       due_word;
	logic [BASE_W-1:0] radix_reg;

	// Queues the digits of one value, most significant first.
	function automatic void queue_digits(input logic [IN_W-1:0] v, input logic [BASE_W-1:0] raw);
		logic [63:0] radix;
		logic [63:0] weight;
		logic [63:0] rest;
		logic [63:0] q;
		int          count;
		digit_word_t w;
		radix = (raw < 2) ? 64'd2 : (raw > 16) ? 64'd16 : 64'(raw);
		if (v == '0) begin
			w.digit   = '0;
			w.is_last = 1'b1;
			digits_due.push_back(w);
			return;
		end
		weight = 64'd1;
		count  = 1;
		while (weight <= 64'(v) / radix) begin
			weight = weight * radix;
			count++;
		end
		rest = 64'(v);
		while (count > 0) begin
			q      = rest / weight;
			rest   = rest - q * weight;
			weight = weight / radix;
			count--;
			w.digit   = q[DIGIT_W-1:0];
			w.is_last = (count == 0);
			digits_due.push_back(w);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_reg = BASE_RESET;
			digits_due.delete();
			digits_outstanding = 0;
		end else begin
			if (cfg_we) begin
				radix_reg = cfg_wdata;
			end
			if (in_valid && in_ready) begin
				queue_digits(value, radix_reg);
			end
			if (out_valid && out_ready) begin
				if (digits_due.size() == 0) begin
					$display("%0t: unexpected digit word, expected none, got digit %0d last %0b",
						$time, digit, last_digit);
					mismatches++;
				end else begin
					due_word = digits_due.pop_front();
					if (digit !== due_word.digit) begin
						$display("%0t: digit mismatch, expected %0d, got %0d",
							$time, due_word.digit, digit);
						mismatches++;
					end
					if (last_digit !== due_word.is_last) begin
						$display("%0t: last_digit mismatch, expected %0b, got %0b",
							$time, due_word.is_last, last_digit);
						mismatches++;
					end
				end
			end
			digits_outstanding = digits_due.size();
		end
	end

endmodule

// ===== sim/testbench.sv =====
// Top level of the radix converter bench. It generates clock and reset, drives value words
// and radix writes, and plays the part of the digit receiver. All prediction and comparison
// is done by the checker instantiated alongside the block; this module only decides the
// verdict from the checker's mismatch count.
module testbench;
	import rtd_pkg::*;

	// Generous ceiling, allowing for the longest values in radix two and for the receiver
	// stalling more than half of the time.
	localparam int CYCLE_LIMIT     = 500000;
	// Length of the deliberate receiver hold-off that backs the block up.
	localparam int HOLD_OFF_CYCLES = 300;
	// Enough to cover the slowest value after the last digit word was expected.
	localparam int TAIL_CYCLES     = 150;

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic [BASE_W-1:0]  cfg_wdata;
	logic               in_valid;
	logic               in_ready;
	logic [IN_W-1:0]    value;
	logic               out_valid;
	logic               out_ready;
	logic [DIGIT_W-1:0] digit;
	logic               last_digit;

	int mismatches;
	int digits_outstanding;
	int cycle_count;
	int send_idle_pct;
	int recv_idle_pct;
	bit hold_off_armed;
	bit hold_off_done;

	integer_to_radix_digits_unit u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.value      (value),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.digit      (digit),
		.last_digit (last_digit)
	);

	radix_digit_checker u_checker (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg_we             (cfg_we),
		.cfg_wdata          (cfg_wdata),
		.in_valid           (in_valid),
		.in_ready           (in_ready),
		.value              (value),
		.out_valid          (out_valid),
		.out_ready          (out_ready),
		.digit              (digit),
		.last_digit         (last_digit),
		.mismatches         (mismatches),
		.digits_outstanding (digits_outstanding)
	);

	initial begin
		clk = 1'b0;
		forever begin
			#2 clk = ~clk;
		end
	end

	// Watchdog: a hung handshake ends the run here.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
			$display("testbench: FAIL");
			$finish;
		end
	end

	// Digit receiver. Ready is drawn afresh every cycle from the current idle rate. When the
	// top arms the hold-off, ready is held low for a long, counted stretch so that the block
	// cannot hand over its digits, backs up and drops in_ready while values keep coming.
	initial begin
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off_armed && !hold_off_done) begin
				out_ready <= 1'b0;
				for (int n = 1; n < HOLD_OFF_CYCLES; n++) begin
					@(posedge clk);
				end
				hold_off_done = 1'b1;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// Offers one value word, after a random number of idle cycles, and returns at the clock
	// edge where it is taken. Valid is left high so that the next word can follow at once.
	task automatic send_value(input logic [IN_W-1:0] v);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		value    <= v;
		do begin
			@(posedge clk);
		end while (!in_ready);
	endtask

	// Stops offering and waits until every predicted digit word has come out. The count is
	// looked at on the falling edge, by which time the checker has settled for the cycle.
	// Returns just after a rising edge, with the block idle.
	task automatic wait_drained();
		in_valid <= 1'b0;
		do begin
			@(negedge clk);
		end while (digits_outstanding != 0);
		@(posedge clk);
	endtask

	// Writes the radix register; only called while the block is idle.
	task automatic write_base(input logic [BASE_W-1:0] raw);
		cfg_we    <= 1'b1;
		cfg_wdata <= raw;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	// One random stretch under a single radix setting. Values are a mixture of full-width
	// random words, words of random length, powers of the radix and their neighbours (where
	// the digit count steps up), short values and lone digits.
	task automatic run_chunk(input logic [BASE_W-1:0] raw, input int items, input bit squeeze);
		logic [63:0]     radix;
		logic [63:0]     power;
		logic [IN_W-1:0] v;
		int              k;
		radix = (raw < 2) ? 64'd2 : (raw > 16) ? 64'd16 : 64'(raw);
		wait_drained();
		write_base(raw);
		if (squeeze) begin
			hold_off_armed = 1'b1;
		end
		for (int i = 0; i < items; i++) begin
			case ($urandom_range(5)) inside
				0: begin
					v = $urandom;
				end
				1: begin
					v = $urandom >> $urandom_range(31);
				end
				2, 3: begin
					power = 64'd1;
					k = $urandom_range(31);
					while (k > 0 && power * radix <= 64'hFFFF_FFFF) begin
						power = power * radix;
						k--;
					end
					v = IN_W'(power + 64'($urandom_range(2)) - 64'd1);
				end
				4: begin
					v = $urandom_range(32'(radix * radix));
				end
				default: begin
					v = $urandom_range(32'(radix - 1));
				end
			endcase
			send_value(v);
		end
	endtask

	initial begin
		arst_n         = 1'b0;
		cfg_we         = 1'b0;
		cfg_wdata      = '0;
		in_valid       = 1'b0;
		value          = '0;
		cycle_count    = 0;
		hold_off_armed = 1'b0;
		hold_off_done  = 1'b0;
		send_idle_pct  = 15;
		recv_idle_pct  = 56;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. First under the radix left by reset (ten): zero, single digits,
		// the step from one digit to two, and the widest value.
		send_value(32'd0);
		send_value(32'd1);
		send_value(32'd9);
		send_value(32'd10);
		send_value(32'd99);
		send_value(32'd1000);
		send_value(32'hFFFF_FFFF);

		// Radix two gives the longest digit strings, 32 words for the widest value.
		wait_drained();
		write_base(BASE_W'(2));
		send_value(32'd0);
		send_value(32'd1);
		send_value(32'd2);
		send_value(32'hFFFF_FFFF);
		send_value(32'h8000_0000);

		// Radix sixteen exercises the largest digit value.
		wait_drained();
		write_base(BASE_W'(16));
		send_value(32'hFFFF_FFFF);
		send_value(32'd15);
		send_value(32'd16);
		send_value(32'h1000_0000);

		// Register settings outside two to sixteen saturate to the nearer end.
		wait_drained();
		write_base(BASE_W'(0));
		send_value(32'd5);
		wait_drained();
		write_base(BASE_W'(31));
		send_value(32'hDEAD_BEEF);
		wait_drained();
		write_base(BASE_W'(1));
		send_value(32'd3);
		wait_drained();
		write_base(BASE_W'(17));
		send_value(32'd17);

		// Radix three: the next power above the widest value no longer fits in 32 bits,
		// and three to the twentieth is an exact power with a one and twenty zeros.
		wait_drained();
		write_base(BASE_W'(3));
		send_value(32'hFFFF_FFFF);
		send_value(32'd3486784401);

		// Random part in three idling regimes. The last one has no idling of its own but
		// carries the long receiver hold-off at the start of its first stretch.
		for (int mode = 0; mode < 3; mode++) begin
			case (mode)
				0: begin
					send_idle_pct = 15;
					recv_idle_pct = 56;
				end
				1: begin
					send_idle_pct = 56;
					recv_idle_pct = 15;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			for (int c = 0; c < 4; c++) begin
				run_chunk(($urandom_range(3) == 0) ? BASE_W'($urandom_range(31))
					: BASE_W'($urandom_range(16, 2)), 24, (mode == 2) && (c == 0));
			end
		end

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);

		if (mismatches == 0) begin
			$display("testbench: PASS");
		end else begin
			$display("testbench: FAIL");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
design/rtd_pkg.sv
design/rtd_ram.sv
design/integer_to_radix_digits_unit.sv
sim/radix_digit_checker.sv
sim/testbench.sv
